FILE: design/ising_cftp_site_update_macros.svh
// Assertion macros for the CFTP site update block.
// Every macro takes a label, the clock, the active-low reset and the property terms.
`ifndef ISING_CFTP_SITE_UPDATE_MACROS_SVH
`define ISING_CFTP_SITE_UPDATE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ICSU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("icsu check failed");

// next-cycle implication
`define ICSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("icsu check failed");

`else

`define ICSU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ICSU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/icsu_pkg.sv
`timescale 1ns / 1ps

package icsu_pkg;

    // spin codes
    localparam logic [1:0] SPIN_DOWN  = 2'd0;
    localparam logic [1:0] SPIN_UNDET = 2'd1;
    localparam logic [1:0] SPIN_UP    = 2'd2;

    // item kinds
    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_WRITE  = 1'b1;

    localparam int DEF_SIDE   = 256;
    localparam int COORD_W    = 8;
    localparam int COORD_SPAN = 2 ** COORD_W;
    localparam int COUNT_W    = 17;
    localparam int FRAC_W     = 32;
    localparam int NUM_THRESH = 5;
    localparam int ADDR_W     = 5;

    // register indexes
    localparam logic [2:0] REG_THRESH_ZERO  = 3'd0;
    localparam logic [2:0] REG_THRESH_ONE   = 3'd1;
    localparam logic [2:0] REG_THRESH_TWO   = 3'd2;
    localparam logic [2:0] REG_THRESH_THREE = 3'd3;
    localparam logic [2:0] REG_THRESH_FOUR  = 3'd4;

    typedef logic [FRAC_W-1:0] frac_t;

    localparam frac_t THRESH_RESET [NUM_THRESH] = '{
        32'd122816737, 32'd628983400, 32'd2147483648, 32'd3665983896, 32'd4172150559
    };

endpackage

FILE: design/ising_cftp_site_update.sv
`timescale 1ns / 1ps
// Heat-bath site update for coupling from the past on a SIDE x SIDE torus of
// three-valued spins (0 down, 1 undetermined, 2 up). An update beat reads the
// grid memory, which has two read ports, in S_IDLE, S_RD1 and S_RD2 for five
// reads (the site itself and its four wrapped neighbours), then decides and
// writes back in S_RD3. A direct write beat reads the old value and writes back
// in S_RD1. The result is registered on write-back. A write-back waits while
// the previous result is stalled. Items are handled one at a time; the next
// item is accepted while a finished result still waits in the output register.
// After reset the block sweeps all 2^(2*ceil(log2(SIDE))) grid sites (65536 at
// SIDE 256) to undetermined, one site per cycle, and stalls its input during
// that pass; threshold registers can be written at any time meanwhile.
`include "ising_cftp_site_update_macros.svh"

module ising_cftp_site_update
    import icsu_pkg::*;
#(
    parameter int SIDE = DEF_SIDE
) (
    input  logic               clk,
    input  logic               rst_n,
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [FRAC_W-1:0]  pwdata,
    output logic [FRAC_W-1:0]  prdata,
    output logic               pready,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [COORD_W-1:0] col,
    input  logic [COORD_W-1:0] row,
    input  logic [FRAC_W-1:0]  random_fraction,
    input  logic [1:0]         write_value,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         new_value,
    output logic [COUNT_W-1:0] undetermined_count
);

    localparam int CW    = $clog2(SIDE);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;
    localparam logic [CW-1:0] LAST = CW'(SIDE - 1);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(SIDE * SIDE);
    localparam bit COUNT_EXACT = (SIDE * SIDE) < (2 ** COUNT_W);

    // sequencer codes
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD1   = 3'd2;
    localparam logic [2:0] S_RD2   = 3'd3;
    localparam logic [2:0] S_RD3   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    frac_t               thr_reg [NUM_THRESH];
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          new_value_reg, new_value_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    // item payload
    logic                act_reg;
    logic [CW-1:0]       c_reg, r_reg;
    frac_t               rnd_reg;
    logic [1:0]          wv_reg;
    logic [1:0]          own_reg, own_next;
    logic [2:0]          n1_reg, n1_next;
    logic [2:0]          n2_reg, n2_next;
    logic                capture;

    // grid memory
    logic [1:0]          grid_mem [DEPTH];
    logic [1:0]          rd_a_reg, rd_b_reg;
    logic                rd_en;
    logic [AW-1:0]       rd_addr_a, rd_addr_b;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [1:0]          mem_wdata;

    // coordinate reduction table
    logic [CW-1:0]       mod_tab [COORD_SPAN];
    logic [CW-1:0]       col_m, row_m, col_p1;
    logic [CW-1:0]       c_m1, c_p1_s, r_m1, r_p1;

    logic                out_free;
    logic [2:0]          n1_tot, n2_tot;
    logic                is_up, is_undet;
    logic [1:0]          upd_value, old_value;
    logic                cfg_we;
    logic [2:0]          cfg_idx;

    // build the modulo table at elaboration
    for (genvar gi = 0; gi < COORD_SPAN; gi++)
    begin : g_mod
        assign mod_tab[gi] = CW'(gi % SIDE);
    end

    assign col_m  = mod_tab[col];
    assign row_m  = mod_tab[row];
    assign col_p1 = (col_m == LAST) ? '0 : col_m + CW'(1);
    assign c_m1   = (c_reg == '0) ? LAST : c_reg - CW'(1);
    assign c_p1_s = (c_reg == LAST) ? '0 : c_reg + CW'(1);
    assign r_m1   = (r_reg == '0) ? LAST : r_reg - CW'(1);
    assign r_p1   = (r_reg == LAST) ? '0 : r_reg + CW'(1);

    // config port
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_comb
    begin
        unique case (cfg_idx)
            REG_THRESH_ZERO:  prdata = thr_reg[0];
            REG_THRESH_ONE:   prdata = thr_reg[1];
            REG_THRESH_TWO:   prdata = thr_reg[2];
            REG_THRESH_THREE: prdata = thr_reg[3];
            REG_THRESH_FOUR:  prdata = thr_reg[4];
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_THRESH; i++)
            begin
                thr_reg[i] <= THRESH_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_THRESH_ZERO:  thr_reg[0] <= pwdata;
                REG_THRESH_ONE:   thr_reg[1] <= pwdata;
                REG_THRESH_TWO:   thr_reg[2] <= pwdata;
                REG_THRESH_THREE: thr_reg[3] <= pwdata;
                REG_THRESH_FOUR:  thr_reg[4] <= pwdata;
                default:          ;
            endcase
        end
    end

    // heat-bath decision from the final neighbour counts
    assign n1_tot    = n1_reg + {2'b00, |rd_a_reg};
    assign n2_tot    = n2_reg + {2'b00, rd_a_reg[1]};
    assign is_up     = rnd_reg < thr_reg[n2_tot];
    assign is_undet  = rnd_reg < thr_reg[n1_tot];
    assign upd_value = is_up ? SPIN_UP : (is_undet ? SPIN_UNDET : SPIN_DOWN);

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign capture   = (state_reg == S_IDLE) && in_valid;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg && out_stall;
        new_value_next = new_value_reg;
        count_next     = count_reg;
        own_next       = own_reg;
        n1_next        = n1_reg;
        n2_next        = n2_reg;
        rd_en          = 1'b0;
        rd_addr_a      = {r_m1, c_reg};
        rd_addr_b      = {r_p1, c_reg};
        mem_we         = 1'b0;
        mem_waddr      = {r_reg, c_reg};
        mem_wdata      = SPIN_UNDET;
        old_value      = own_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = SPIN_UNDET;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == {AW{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                // read own site and the right neighbour
                rd_addr_a = {row_m, col_m};
                rd_addr_b = {row_m, col_p1};
                if (in_valid)
                begin
                    rd_en      = 1'b1;
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                if (act_reg == ACT_WRITE)
                begin
                    old_value = rd_a_reg;
                    if (out_free)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = (wv_reg == 2'd3) ? SPIN_UP : wv_reg;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    // left and lower neighbours next
                    rd_en      = 1'b1;
                    rd_addr_a  = {r_reg, c_m1};
                    rd_addr_b  = {r_p1, c_reg};
                    own_next   = rd_a_reg;
                    n1_next    = {2'b00, |rd_b_reg};
                    n2_next    = {2'b00, rd_b_reg[1]};
                    state_next = S_RD2;
                end
            end
            S_RD2:
            begin
                // upper neighbour last
                rd_en      = 1'b1;
                rd_addr_a  = {r_m1, c_reg};
                rd_addr_b  = {r_m1, c_p1_s};
                n1_next    = n1_reg + {2'b00, |rd_a_reg} + {2'b00, |rd_b_reg};
                n2_next    = n2_reg + {2'b00, rd_a_reg[1]} + {2'b00, rd_b_reg[1]};
                state_next = S_RD3;
            end
            S_RD3:
            begin
                if (out_free)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = upd_value;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // count and result load on write-back of an item
        if (mem_we && (state_reg != S_CLEAR))
        begin
            out_valid_next = 1'b1;
            new_value_next = mem_wdata;
            if ((old_value == SPIN_UNDET) && (mem_wdata != SPIN_UNDET))
            begin
                count_next = count_reg - COUNT_W'(1);
            end
            else if ((old_value != SPIN_UNDET) && (mem_wdata == SPIN_UNDET))
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            act_reg <= action;
            c_reg   <= col_m;
            r_reg   <= row_m;
            rnd_reg <= random_fraction;
            wv_reg  <= write_value;
        end
        own_reg       <= own_next;
        n1_reg        <= n1_next;
        n2_reg        <= n2_next;
        new_value_reg <= new_value_next;
    end

    // grid memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_a_reg <= grid_mem[rd_addr_a];
            rd_b_reg <= grid_mem[rd_addr_b];
        end
    end

    assign out_valid          = out_valid_reg;
    assign new_value          = new_value_reg;
    assign undetermined_count = count_reg;

    // checks
    `ICSU_ASSERT_NEXT(a_accept_starts_read, clk, rst_n, in_valid && !in_stall, state_reg == S_RD1)
    `ICSU_ASSERT_IMPL(a_result_after_write, clk, rst_n, $rose(out_valid_reg), $past(mem_we))
    `ICSU_ASSERT_IMPL(a_no_code_three, clk, rst_n, mem_we, mem_wdata != 2'd3)
    `ICSU_ASSERT_IMPL(a_count_bound, clk, rst_n, COUNT_EXACT, count_reg <= COUNT_RESET)

endmodule

FILE: sim/ising_cftp_site_update_monitor.sv
`timescale 1ns / 1ps

module ising_cftp_site_update_monitor
    import icsu_pkg::*;
#(
    parameter int SIDE = DEF_SIDE
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [FRAC_W-1:0]  pwdata,
    input  logic               pready,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               action,
    input  logic [COORD_W-1:0] col,
    input  logic [COORD_W-1:0] row,
    input  logic [FRAC_W-1:0]  random_fraction,
    input  logic [1:0]         write_value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [1:0]         new_value,
    input  logic [COUNT_W-1:0] undetermined_count,
    output int                 fail_count,
    output int                 pending
);

    localparam int SITES = SIDE * SIDE;

    typedef struct packed {
        logic [1:0]         spin;
        logic [COUNT_W-1:0] undet;
    } site_result_t;

    logic [1:0]   lattice [SITES];
    frac_t        thresh_copy [NUM_THRESH];
    int           undet_sites;
    site_result_t spin_results_due [$];
    int           bad_beats = 0;
    int           results_waiting = 0;

    assign fail_count = bad_beats;
    assign pending    = results_waiting;

    function automatic int site_of(input int c, input int r);
        return (r % SIDE) * SIDE + (c % SIDE);
    endfunction

    // heat-bath choice from the four wrapped neighbours
    function automatic logic [1:0] heat_bath_spin(input int c, input int r, input frac_t frac);
        int nb [4];
        int n_live;
        int n_up;
        nb[0] = site_of(c + 1, r);
        nb[1] = site_of(c + SIDE - 1, r);
        nb[2] = site_of(c, r + 1);
        nb[3] = site_of(c, r + SIDE - 1);
        n_live = 0;
        n_up = 0;
        for (int k = 0; k < 4; k++)
        begin
            if (lattice[nb[k]] >= SPIN_UNDET) n_live++;
            if (lattice[nb[k]] >= SPIN_UP) n_up++;
        end
        if (frac < thresh_copy[n_up]) return SPIN_UP;
        if (frac < thresh_copy[n_live]) return SPIN_UNDET;
        return SPIN_DOWN;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [2:0]   reg_idx;
        int           site;
        logic [1:0]   spin;
        site_result_t want;
        if (!rst_n)
        begin
            foreach (lattice[i]) lattice[i] = SPIN_UNDET;
            thresh_copy = THRESH_RESET;
            undet_sites = SITES;
            spin_results_due.delete();
            results_waiting = 0;
        end
        else
        begin
            // follow threshold writes, drop unused indexes
            if (psel && penable && pwrite && pready)
            begin
                reg_idx = paddr[ADDR_W-1:2];
                if (reg_idx < NUM_THRESH) thresh_copy[reg_idx] = pwdata;
            end

            // predict the site value and running count for an accepted beat
            if (in_valid && !in_stall)
            begin
                site = site_of(col, row);
                if (action == ACT_WRITE)
                    spin = (write_value > SPIN_UP) ? SPIN_UP : write_value;
                else
                    spin = heat_bath_spin(col, row, random_fraction);
                if (lattice[site] == SPIN_UNDET && spin != SPIN_UNDET) undet_sites--;
                if (lattice[site] != SPIN_UNDET && spin == SPIN_UNDET) undet_sites++;
                lattice[site] = spin;
                want.spin = spin;
                want.undet = COUNT_W'(undet_sites);
                spin_results_due.insert(spin_results_due.size(), want);
            end

            // compare an accepted result beat with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (spin_results_due.size() == 0)
                begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("%0t: result beat with nothing predicted: value %0d count %0d",
                                 $realtime, new_value, undetermined_count);
                end
                else
                begin
                    want = spin_results_due.pop_front();
                    if (new_value !== want.spin || undetermined_count !== want.undet)
                    begin
                        bad_beats++;
                        if (bad_beats <= 10)
                            $display("%0t: result mismatch: value %0d count %0d, expected %0d %0d",
                                     $realtime, new_value, undetermined_count,
                                     want.spin, want.undet);
                    end
                end
            end

            results_waiting = spin_results_due.size();
        end
    end

endmodule

FILE: sim/ising_cftp_site_update_tb.sv
`timescale 1ns / 1ps

module ising_cftp_site_update_tb;
    import icsu_pkg::*;

    localparam int         QUIET_LIMIT    = 200000;
    localparam int         PHASE_ITEMS    = 245;
    localparam int         NUM_PHASES     = 6;
    localparam logic [2:0] REG_SPARE_LOW  = 3'd5;
    localparam logic [2:0] REG_SPARE_HIGH = 3'd7;
    localparam logic [1:0] WV_OVERRANGE   = 2'd3;
    localparam frac_t      FRAC_MAX       = '1;
    localparam logic [2:0] THRESH_REGS [NUM_THRESH] = '{
        REG_THRESH_ZERO, REG_THRESH_ONE, REG_THRESH_TWO, REG_THRESH_THREE, REG_THRESH_FOUR
    };

    typedef enum logic [1:0] {
        SINK_FREE,
        SINK_LIGHT,
        SINK_HEAVY,
        SINK_BLOCKED
    } sink_mode_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [FRAC_W-1:0]  pwdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic               action;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [FRAC_W-1:0]  random_fraction;
    logic [1:0]         write_value;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         new_value;
    logic [COUNT_W-1:0] undetermined_count;

    int         fail_count;
    int         pending;
    frac_t      thr_now [NUM_THRESH];
    int         burst_left = 0;
    int         quiet_cycles = 0;
    sink_mode_t sink_mode = SINK_FREE;
    int         sink_left = 0;

    ising_cftp_site_update u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (),
        .pready             (pready),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .action             (action),
        .col                (col),
        .row                (row),
        .random_fraction    (random_fraction),
        .write_value        (write_value),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .new_value          (new_value),
        .undetermined_count (undetermined_count)
    );

    ising_cftp_site_update_monitor u_monitor (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .pready             (pready),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .action             (action),
        .col                (col),
        .row                (row),
        .random_fraction    (random_fraction),
        .write_value        (write_value),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .new_value          (new_value),
        .undetermined_count (undetermined_count),
        .fail_count         (fail_count),
        .pending            (pending)
    );

    always #5 clk = ~clk;

    // give up when no beat and no register access moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("ising_cftp_site_update verification failed");
                $finish;
            end
        end
    end

    // result side backpressure, switching between patterns
    always @(negedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_mode <= sink_mode_t'($urandom_range(0, 3));
            sink_left <= $urandom_range(20, 200);
        end
        else
            sink_left <= sink_left - 1;
        case (sink_mode)
            SINK_FREE:    out_stall <= 1'b0;
            SINK_LIGHT:   out_stall <= ($urandom_range(0, 3) == 0);
            SINK_HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
            SINK_BLOCKED: out_stall <= ((sink_left % 32) >= 8);
        endcase
    end

    // offer one beat, with a random gap at the start of each burst
    task automatic send_item(input logic act, input logic [COORD_W-1:0] c,
                             input logic [COORD_W-1:0] r, input frac_t frac,
                             input logic [1:0] wv);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid        <= 1'b1;
        action          <= act;
        col             <= c;
        row             <= r;
        random_fraction <= frac;
        write_value     <= wv;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // hold the sender until every predicted result has come back
    task automatic settle_results();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input frac_t value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < NUM_THRESH) thr_now[idx] = value;
    endtask

    // fractions cluster around the live thresholds and the extremes
    function automatic frac_t pick_fraction();
        int sel;
        int k;
        sel = $urandom_range(0, 99);
        k = $urandom_range(0, NUM_THRESH - 1);
        if (sel < 25) return thr_now[k] + frac_t'($urandom_range(0, 4)) - frac_t'(2);
        if (sel < 30) return '0;
        if (sel < 35) return FRAC_MAX;
        return $urandom;
    endfunction

    task automatic apply_thresholds(input int phase);
        frac_t v;
        v = '0;
        for (int k = 0; k < NUM_THRESH; k++)
        begin
            case (phase)
                1: v = '0;
                2: v = FRAC_MAX;
                3: v = $urandom;
                4: v = v + frac_t'($urandom_range(0, 32'h3333_3333));
                5: v = (k % 2 == 0) ? FRAC_MAX : '0;
                default: v = THRESH_RESET[k];
            endcase
            write_reg(THRESH_REGS[k], v);
        end
        // unused indexes must not disturb anything
        if (phase == 3)
        begin
            write_reg(REG_SPARE_LOW, $urandom);
            write_reg(REG_SPARE_HIGH, $urandom);
        end
    endtask

    // mostly small patches, often across the torus seam, with some stray sites
    task automatic run_lattice_phase(input int n_items);
        int                 done;
        int                 span;
        int                 left;
        int                 pick;
        logic [COORD_W-1:0] base_c;
        logic [COORD_W-1:0] base_r;
        logic [COORD_W-1:0] c;
        logic [COORD_W-1:0] r;
        logic               act;
        logic [1:0]         wv;
        done = 0;
        while (done < n_items)
        begin
            span = $urandom_range(2, 6);
            base_c = ($urandom_range(0, 2) == 0) ? COORD_W'(DEF_SIDE - $urandom_range(1, 3))
                                                 : COORD_W'($urandom);
            base_r = ($urandom_range(0, 2) == 0) ? COORD_W'(DEF_SIDE - $urandom_range(1, 3))
                                                 : COORD_W'($urandom);
            left = $urandom_range(10, 60);
            while (left > 0 && done < n_items)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    c = COORD_W'($urandom);
                    r = COORD_W'($urandom);
                end
                else
                begin
                    c = base_c + COORD_W'($urandom_range(0, span - 1));
                    r = base_r + COORD_W'($urandom_range(0, span - 1));
                end
                act = ($urandom_range(0, 99) < 35) ? ACT_WRITE : ACT_UPDATE;
                pick = $urandom_range(0, 9);
                wv = (pick < 3) ? SPIN_DOWN : (pick < 6) ? SPIN_UNDET
                   : (pick < 9) ? SPIN_UP : WV_OVERRANGE;
                send_item(act, c, r, pick_fraction(), wv);
                if ($urandom_range(0, 149) == 0) settle_results();
                left--;
                done++;
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_valid        = 1'b0;
        action          = ACT_UPDATE;
        col             = '0;
        row             = '0;
        random_fraction = '0;
        write_value     = SPIN_DOWN;
        thr_now         = THRESH_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fresh grid: updates among undetermined neighbours, the last beside the updated origin
        send_item(ACT_UPDATE, 8'h00, 8'h00, '0, SPIN_DOWN);
        send_item(ACT_UPDATE, 8'hFF, 8'hFF, FRAC_MAX, WV_OVERRANGE);
        send_item(ACT_UPDATE, 8'h80, 8'h80, thr_now[0], SPIN_UP);
        send_item(ACT_UPDATE, 8'h01, 8'h00, '0, SPIN_DOWN);
        // fence the origin across the seam, one side by an overrange write
        send_item(ACT_WRITE, 8'h01, 8'h00, FRAC_MAX, SPIN_UP);
        send_item(ACT_WRITE, 8'hFF, 8'h00, '0, WV_OVERRANGE);
        send_item(ACT_WRITE, 8'h00, 8'h01, 32'hA5A5_A5A5, SPIN_DOWN);
        send_item(ACT_WRITE, 8'h00, 8'hFF, 32'h5A5A_5A5A, SPIN_UP);
        send_item(ACT_UPDATE, 8'h00, 8'h00, thr_now[3] - 1, SPIN_DOWN);
        send_item(ACT_UPDATE, 8'h00, 8'h00, thr_now[3], SPIN_DOWN);
        send_item(ACT_WRITE, 8'h00, 8'h01, '0, SPIN_UNDET);
        send_item(ACT_UPDATE, 8'h00, 8'h00, thr_now[3], SPIN_DOWN);
        send_item(ACT_UPDATE, 8'h00, 8'h00, thr_now[4] - 1, SPIN_UP);
        send_item(ACT_UPDATE, 8'h00, 8'h00, thr_now[4], SPIN_UNDET);
        send_item(ACT_WRITE, 8'h00, 8'h00, '0, SPIN_UNDET);
        send_item(ACT_WRITE, 8'hAA, 8'h55, FRAC_MAX, SPIN_DOWN);
        send_item(ACT_UPDATE, 8'h55, 8'hAA, 32'h5555_5555, WV_OVERRANGE);
        send_item(ACT_WRITE, 8'hFF, 8'hFF, '0, SPIN_UNDET);
        send_item(ACT_WRITE, 8'hFF, 8'hFF, FRAC_MAX, SPIN_UNDET);
        run_lattice_phase(PHASE_ITEMS);

        // walk through threshold settings, extremes included
        for (int p = 1; p <= NUM_PHASES; p++)
        begin
            settle_results();
            apply_thresholds(p);
            send_item(ACT_UPDATE, COORD_W'($urandom), COORD_W'($urandom), '0, SPIN_DOWN);
            send_item(ACT_UPDATE, COORD_W'($urandom), COORD_W'($urandom), FRAC_MAX, SPIN_UP);
            run_lattice_phase(PHASE_ITEMS);
        end

        settle_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ising_cftp_site_update verification clean");
        else
            $display("ising_cftp_site_update verification failed");
        $finish;
    end

endmodule
